// ===== design/hmnm_pkg.sv =====
// ----------------------------------------------------------------------------
// Height map to normal map package
// Shared types, constants and codes for the Sobel normal unit.
// ----------------------------------------------------------------------------
package hmnm_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int CFG_W          = 9;
    localparam int COORD_W        = 8;
    localparam int SAMPLE_W       = 8;
    localparam int GRAD_W         = 12;   // |g| <= 1020
    localparam int SQ_W           = 22;   // 2*1020^2 + 65025 < 2^22
    localparam int LEN_W          = 11;   // sqrt < 2^11
    localparam int NUM_W          = 20;   // 255 * 2*2^11 < 2^20
    localparam int QUO_W          = 8;

    localparam logic [CFG_W-1:0] SIZE_LIMIT = 9'd256;

    localparam logic [0:0] REQ_WRITE   = 1'b0;
    localparam logic [0:0] REQ_COMPUTE = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ACCUM,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] normal_x;
        logic [COORD_W-1:0] normal_y;
        logic [COORD_W-1:0] normal_z;
        logic               bad_coordinate;
    } result_t;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] height_value;
    } request_t;

    typedef struct packed {
        logic [CFG_W-2:0]   index;
        logic [CFG_W-1:0]   data;
    } cfg_write_t;

endpackage

// ===== design/hmnm_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Request, result and configuration channels with source and sink views.
// ----------------------------------------------------------------------------
interface hmnm_req_if;
    import hmnm_pkg::*;
    logic     valid;
    logic     ready;
    request_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hmnm_res_if;
    import hmnm_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hmnm_cfg_if;
    import hmnm_pkg::*;
    logic       valid;
    logic       ready;
    cfg_write_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/hmnm_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Shared iterative unit: one quotient bit per cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module hmnm_divider
    import hmnm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [LEN_W:0]   denom,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    // quotient fits in 8 bits, so compare against the denominator shifted from bit 7 down
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [3:0]       step_reg, step_next;
    logic [LEN_W:0]   den_reg;
    logic [NUM_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        trial     = {1'b0, rem_reg} -
                    ({{(NUM_W-LEN_W){1'b0}}, den_reg} << step_reg[2:0]);
        if (start)
        begin
            rem_next  = numer;
            quo_next  = '0;
            step_next = 4'd8;
        end
        else if (step_reg != 4'd0)
        begin
            step_next = step_reg - 4'd1;
        end
        if (!start && step_reg != 4'd0)
        begin
            trial = {1'b0, rem_reg} -
                    ({{(NUM_W-LEN_W){1'b0}}, den_reg} << (step_reg[2:0] - 3'd1));
            if (!trial[NUM_W])
            begin
                rem_next = trial[NUM_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign busy     = (step_reg != 4'd0);
    assign quotient = quo_reg;

endmodule

// ===== design/height_map_to_normal_map_unit.sv =====
// ----------------------------------------------------------------------------
// Height map to normal map unit
// Frame store of height samples; Sobel normal per compute transaction.
// ----------------------------------------------------------------------------
// Write transaction: stored on acceptance if inside the store, and ready again the next cycle.
// Compute transaction: the result follows nine reads from the single frame
// memory port, two squares, a bit-pair square root and three divisions on one
// shared divider. Ready again the cycle after the result is taken; a bad
// coordinate answers on the next cycle. Reset sets the size registers to
// 256 x 256; the frame store is not cleared and a sample reads as undefined
// until written.
module height_map_to_normal_map_unit
    import hmnm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic   clk,
    input  logic   rst_n,
    hmnm_req_if.sink   req,
    hmnm_res_if.source res,
    hmnm_cfg_if.sink   cfg
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W:0] MAXW_C = (MAX_WIDTH  > 256) ? 10'd256 : 10'(MAX_WIDTH);
    localparam logic [CFG_W:0] MAXH_C = (MAX_HEIGHT > 256) ? 10'd256 : 10'(MAX_HEIGHT);

    logic [SAMPLE_W-1:0] store [DEPTH];

    state_t state_reg, state_next;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic [CFG_W-1:0] cl_reg, cr_reg, ra_reg, rb_reg;
    logic [3:0] tap_reg, tap_next;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] root_v_reg, root_r_reg, root_b_reg;
    logic [1:0] comp_reg;
    logic [QUO_W-1:0] nx_reg, ny_reg;
    logic [SAMPLE_W-1:0] rd_reg;
    logic res_valid_reg;
    result_t res_reg;

    logic [CFG_W-1:0] w_eff, h_eff;
    logic req_fire, div_start, div_busy;
    logic [QUO_W-1:0] div_q;
    logic [NUM_W-1:0] div_num;
    logic [CFG_W-1:0] tap_c, tap_r;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [GRAD_W-1:0] wx, wy;
    logic signed [GRAD_W-1:0] sq_op;
    logic [SQ_W-1:0] rb_sum;
    logic signed [LEN_W+1:0] comp_c;

    // effective size: saturate to store size and to 256
    always_comb
    begin
        w_eff = ({1'b0, width_reg}  > MAXW_C) ? MAXW_C[CFG_W-1:0] : width_reg;
        h_eff = ({1'b0, height_reg} > MAXH_C) ? MAXH_C[CFG_W-1:0] : height_reg;
    end

    assign req.ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_LIMIT;
            height_reg <= SIZE_LIMIT;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == {{(CFG_W-2){1'b0}}, REG_WIDTH})
            begin
                width_reg <= cfg.data.data;
            end
            else if (cfg.data.index == {{(CFG_W-2){1'b0}}, REG_HEIGHT})
            begin
                height_reg <= cfg.data.data;
            end
        end
    end

    // tap order: 0..2 = left column (above, centre, below), 3..5 = centre
    // column, 6..8 = right column
    always_comb
    begin
        unique case (tap_reg)
            4'd0, 4'd1, 4'd2: tap_c = cl_reg;
            4'd3, 4'd4, 4'd5: tap_c = {1'b0, col_reg};
            default:          tap_c = cr_reg;
        endcase
        unique case (tap_reg)
            4'd0, 4'd3, 4'd6: tap_r = ra_reg;
            4'd1, 4'd4, 4'd7: tap_r = {1'b0, row_reg};
            default:          tap_r = rb_reg;
        endcase
    end

    // sample (c,r) lives at r*MAX_WIDTH+c
    assign wr_addr = AW'(req.data.row) * AW'(MAX_WIDTH) + AW'(req.data.col);
    assign rd_addr = AW'(tap_r) * AW'(MAX_WIDTH) + AW'(tap_c);

    // store access: writes from requests, reads during fetch
    always_ff @(posedge clk)
    begin
        if (req_fire && req.data.req_type == REQ_WRITE &&
            {2'b00, req.data.col} < MAXW_C &&
            {2'b00, req.data.row} < MAXH_C)
        begin
            store[wr_addr] <= req.data.height_value;
        end
        rd_reg <= store[rd_addr];
    end

    // Sobel weights of the sample that arrived (previous tap)
    always_comb
    begin
        wx = '0;
        wy = '0;
        unique case (tap_reg - 4'd1)
            4'd0: begin wx = -12'sd1; wy =  12'sd1; end
            4'd1: begin wx = -12'sd2; wy =  12'sd0; end
            4'd2: begin wx = -12'sd1; wy = -12'sd1; end
            4'd3: begin wx =  12'sd0; wy =  12'sd2; end
            4'd4: begin wx =  12'sd0; wy =  12'sd0; end
            4'd5: begin wx =  12'sd0; wy = -12'sd2; end
            4'd6: begin wx =  12'sd1; wy =  12'sd1; end
            4'd7: begin wx =  12'sd2; wy =  12'sd0; end
            4'd8: begin wx =  12'sd1; wy = -12'sd1; end
            default: begin wx = '0; wy = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_fire && req.data.req_type == REQ_COMPUTE &&
                    {1'b0, req.data.col} < w_eff && {1'b0, req.data.row} < h_eff)
                begin
                    state_next = ST_FETCH;
                end
            ST_FETCH:     state_next = ST_ACCUM;
            ST_ACCUM:     state_next = (tap_reg == 4'd9) ? ST_SQUARE : ST_ACCUM;
            ST_SQUARE:    state_next = (comp_reg == 2'd1) ? ST_SQRT : ST_SQUARE;
            ST_SQRT:      state_next = (root_b_reg == '0) ? ST_DIV_SETUP : ST_SQRT;
            ST_DIV_SETUP: state_next = ST_DIV;
            ST_DIV:
                if (!div_busy)
                begin
                    state_next = (comp_reg == 2'd2) ? ST_DONE : ST_DIV_SETUP;
                end
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tap_next = tap_reg;
        unique case (state_reg)
            ST_IDLE:  tap_next = 4'd0;
            ST_FETCH, ST_ACCUM: tap_next = (tap_reg == 4'd9) ? tap_reg : tap_reg + 4'd1;
            default:  tap_next = tap_reg;
        endcase
    end

    // squarer: one signed square per cycle, shared by gx and gy
    assign sq_op  = (comp_reg == 2'd0) ? gx_reg : gy_reg;
    assign rb_sum = root_r_reg + root_b_reg;

    // packing: c = -gx, -gy, 255 in turn; numerator 255*(L+c)
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    comp_c = {1'b0, root_r_reg[LEN_W-1:0]} - 13'(gx_reg);
            2'd1:    comp_c = {1'b0, root_r_reg[LEN_W-1:0]} - 13'(gy_reg);
            default: comp_c = {1'b0, root_r_reg[LEN_W-1:0]} + 13'sd255;
        endcase
        div_num = NUM_W'(comp_c[LEN_W:0] * 8'd255);
    end
    assign div_start = (state_reg == ST_DIV_SETUP);

    hmnm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .denom    ({root_r_reg[LEN_W-1:0], 1'b0}),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            if (res.valid && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_DONE ||
                     (req_fire && req.data.req_type == REQ_COMPUTE &&
                      !({1'b0, req.data.col} < w_eff && {1'b0, req.data.row} < h_eff)))
            begin
                res_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                col_reg  <= req.data.col;
                row_reg  <= req.data.row;
                cl_reg   <= (req.data.col == '0) ? w_eff - 9'd1 : {1'b0, req.data.col} - 9'd1;
                cr_reg   <= ({1'b0, req.data.col} == w_eff - 9'd1) ? '0
                            : {1'b0, req.data.col} + 9'd1;
                ra_reg   <= (req.data.row == '0) ? h_eff - 9'd1 : {1'b0, req.data.row} - 9'd1;
                rb_reg   <= ({1'b0, req.data.row} == h_eff - 9'd1) ? '0
                            : {1'b0, req.data.row} + 9'd1;
                gx_reg   <= '0;
                gy_reg   <= '0;
                comp_reg <= 2'd0;
                sq_reg   <= SQ_W'(65025);
                // hold a waiting result
                if (!res_valid_reg)
                begin
                    res_reg <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                 bad_coordinate: 1'b1};
                end
            end
            ST_ACCUM:
            begin
                gx_reg <= gx_reg + wx * $signed({4'd0, rd_reg});
                gy_reg <= gy_reg + wy * $signed({4'd0, rd_reg});
            end
            ST_SQUARE:
            begin
                sq_reg <= sq_reg + SQ_W'(sq_op) * SQ_W'(sq_op);
                if (comp_reg == 2'd1)
                begin
                    root_v_reg <= '0;
                    root_r_reg <= '0;
                    root_b_reg <= SQ_W'(1) << (SQ_W - 2);
                    comp_reg   <= 2'd0;
                end
                else
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                // first pass loads the radicand, then one bit pair per cycle
                if (root_b_reg == (SQ_W'(1) << (SQ_W - 2)) && root_v_reg == '0 &&
                    root_r_reg == '0 && sq_reg != '0)
                begin
                    root_v_reg <= sq_reg;
                    sq_reg     <= '0;
                end
                else if (root_b_reg != '0)
                begin
                    if (root_v_reg >= rb_sum)
                    begin
                        root_v_reg <= root_v_reg - rb_sum;
                        root_r_reg <= (root_r_reg >> 1) + root_b_reg;
                    end
                    else
                    begin
                        root_r_reg <= root_r_reg >> 1;
                    end
                    root_b_reg <= root_b_reg >> 2;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    unique case (comp_reg)
                        2'd0:    nx_reg <= div_q;
                        2'd1:    ny_reg <= div_q;
                        default: res_reg <= '{normal_x: nx_reg, normal_y: ny_reg,
                                              normal_z: div_q, bad_coordinate: 1'b0};
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    property p_busy_not_ready;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready)
        else $error("request taken while a computation runs");

    property p_done_raises_valid;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> res_valid_reg;
    endproperty
    a_done_raises_valid: assert property (p_done_raises_valid)
        else $error("finished computation gave no result");

    property p_div_idle_on_start;
        @(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy;
    endproperty
    a_div_idle_on_start: assert property (p_div_idle_on_start)
        else $error("divider restarted while busy");

endmodule
